FILE: rtl/lsb_pkg.sv
// lsb_pkg: shared types and constants for the lidar scan binner.
// No dependencies; imported by every module under rtl/.
package lsb_pkg;

    localparam int          NUM_BINS_DEFAULT = 180;
    localparam logic [7:0]  SYNC_BYTE        = 8'd165;
    localparam logic [2:0]  HEADER_LAST      = 3'd4;
    localparam logic [2:0]  SAMPLE_LEN       = 3'd5;
    localparam logic [7:0]  GAP_MAX          = 8'd255;
    localparam logic [7:0]  MIN_GAP_RESET    = 8'd10;

    typedef enum logic {CMD_STREAM = 1'b0, CMD_READ = 1'b1} cmd_t;
    typedef enum logic {KIND_SAMPLE = 1'b0, KIND_BIN = 1'b1} kind_t;
    typedef enum logic {PH_HEADER = 1'b0, PH_PAYLOAD = 1'b1} phase_t;

    typedef struct packed {
        logic [5:0]  quality;
        logic [13:0] distance;
    } bin_t;

    // one result candidate travelling from the parser to the bin store
    typedef struct packed {
        kind_t       kind;
        logic [5:0]  quality;
        logic [8:0]  angle;
        logic [13:0] distance;
        logic        rot_start;
        logic        scan_ready;
        logic        oor;
        logic [7:0]  idx;
    } op_t;

endpackage

FILE: rtl/lsb_parser.sv
// lsb_parser: frame parser, sample decode and rotation tracking.
// Depends on lsb_pkg.
module lsb_parser #(
    parameter int NUM_BINS = lsb_pkg::NUM_BINS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             a_vld,
    input  lsb_pkg::cmd_t    cmd,
    input  logic [7:0]       link_byte,
    input  logic [7:0]       bin_index,
    input  logic [7:0]       min_gap,
    output logic             op_vld,
    output lsb_pkg::op_t     op
);
    import lsb_pkg::*;

    localparam logic [8:0] NB = 9'(NUM_BINS);

    phase_t      phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next, pos_inc;
    logic        sync_reg, sync_next;
    logic [23:0] rem_reg, rem_next;
    logic [7:0]  pb_reg [SAMPLE_LEN];
    logic [7:0]  pb_next [SAMPLE_LEN];
    logic [7:0]  pb_view [SAMPLE_LEN];
    logic [7:0]  gap_reg, gap_next;
    logic        seen_reg, seen_next;
    logic        step, decode, adv, start, ready;
    logic [8:0]  ang;

    assign step = en && a_vld && (cmd == CMD_STREAM);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        pos_inc    = pos_reg;
        sync_next  = sync_reg;
        rem_next   = rem_reg;
        pb_next    = pb_reg;
        pb_view    = pb_reg;
        gap_next   = gap_reg;
        seen_next  = seen_reg;
        decode     = 1'b0;
        adv        = 1'b0;
        ready      = 1'b0;
        if (phase_reg == PH_PAYLOAD && pos_reg < SAMPLE_LEN)
        begin
            pb_view[pos_reg] = link_byte;
        end
        ang   = {pb_view[2], pb_view[1][7]};
        start = (ang == 9'd0) && (gap_reg > min_gap);
        if (step)
        begin
            if (phase_reg == PH_HEADER)
            begin
                if (pos_reg == 3'd0)
                begin
                    sync_next = (link_byte == SYNC_BYTE);
                end
                else if (pos_reg == 3'd2)
                begin
                    rem_next = {16'd0, link_byte};
                end
                else if (pos_reg > 3'd2)
                begin
                    rem_next = {rem_reg[15:0], link_byte};
                end
                if (pos_reg < HEADER_LAST)
                begin
                    pos_next = pos_reg + 3'd1;
                end
                else
                begin
                    pos_next = 3'd0;
                    if (!sync_reg || rem_next == 24'd0)
                    begin
                        adv = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            else
            begin
                if (pos_reg < SAMPLE_LEN)
                begin
                    pb_next[pos_reg] = link_byte;
                    pos_inc = pos_reg + 3'd1;
                end
                rem_next = rem_reg - 24'd1;
                if (rem_next == 24'd0)
                begin
                    phase_next = PH_HEADER;
                    pos_next   = 3'd0;
                    if (pos_inc < SAMPLE_LEN)
                    begin
                        adv = 1'b1;
                    end
                    else
                    begin
                        decode = 1'b1;
                    end
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
        end
        if (decode)
        begin
            if (start)
            begin
                gap_next  = 8'd0;
                seen_next = 1'b1;
                ready     = seen_reg;
            end
            else
            begin
                adv = 1'b1;
            end
        end
        if (adv && gap_reg != GAP_MAX)
        begin
            gap_next = gap_reg + 8'd1;
        end
    end

    always_comb
    begin
        op_vld = a_vld && ((cmd == CMD_READ) || decode);
        if (cmd == CMD_READ)
        begin
            op.kind       = KIND_BIN;
            op.quality    = 6'd0;
            op.angle      = 9'd0;
            op.distance   = 14'd0;
            op.rot_start  = 1'b0;
            op.scan_ready = 1'b0;
            op.idx        = bin_index;
            op.oor        = ({1'b0, bin_index} >= NB);
        end
        else
        begin
            op.kind       = KIND_SAMPLE;
            op.quality    = pb_view[0][7:2];
            op.angle      = ang;
            op.distance   = {pb_view[4], pb_view[3][7:2]};
            op.rot_start  = start;
            op.scan_ready = ready;
            op.idx        = ang[8:1];
            op.oor        = ({1'b0, ang[8:1]} >= NB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= 3'd0;
            sync_reg  <= 1'b0;
            rem_reg   <= 24'd0;
            gap_reg   <= GAP_MAX;
            seen_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sync_reg  <= sync_next;
            rem_reg   <= rem_next;
            gap_reg   <= gap_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pb_reg <= pb_next;
    end

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> rem_reg != 24'd0)
        else $error("payload phase with nothing left to consume");

    a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> pos_reg <= HEADER_LAST)
        else $error("header byte position past end of header");

    a_start_clears_gap: assert property (@(posedge clk) disable iff (!rst_n)
        op_vld && en && op.kind == KIND_SAMPLE && op.rot_start |=> gap_reg == 8'd0)
        else $error("rotation start did not restart gap counter");

endmodule

FILE: rtl/lsb_bin_store.sv
// lsb_bin_store: angular bin memory with valid bits, read-modify-write and bin reads.
// Depends on lsb_pkg.
module lsb_bin_store #(
    parameter int NUM_BINS = lsb_pkg::NUM_BINS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             op_vld,
    input  lsb_pkg::op_t     op,
    output logic             res_vld,
    output lsb_pkg::op_t     res
);
    import lsb_pkg::*;

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    bin_t              mem [NUM_BINS];
    bin_t              rd_reg;
    logic              b_vld_reg;
    op_t               b_op_reg;
    logic [NUM_BINS-1:0] valid_reg, valid_next;
    logic              fwd_vld_reg;
    logic [AW-1:0]     fwd_addr_reg;
    bin_t              fwd_data_reg;
    logic [AW-1:0]     a_addr, b_addr;
    bin_t              cur, eff, wdata;
    logic              we;

    assign a_addr = op.oor ? '0 : op.idx[AW-1:0];
    assign b_addr = b_op_reg.oor ? '0 : b_op_reg.idx[AW-1:0];

    always_comb
    begin
        if (fwd_vld_reg && fwd_addr_reg == b_addr)
        begin
            cur = fwd_data_reg;
        end
        else if (valid_reg[b_addr])
        begin
            cur = rd_reg;
        end
        else
        begin
            cur = '0;
        end
        eff = b_op_reg.rot_start ? '0 : cur;
        wdata.quality  = b_op_reg.quality;
        wdata.distance = b_op_reg.distance;
        we = en && b_vld_reg && (b_op_reg.kind == KIND_SAMPLE) && !b_op_reg.oor
            && (b_op_reg.quality > eff.quality);
        valid_next = valid_reg;
        if (b_vld_reg && b_op_reg.kind == KIND_SAMPLE && b_op_reg.rot_start)
        begin
            valid_next = '0;
        end
        if (we)
        begin
            valid_next[b_addr] = 1'b1;
        end
        res_vld = b_vld_reg;
        res     = b_op_reg;
        if (b_op_reg.kind == KIND_BIN)
        begin
            res.quality  = b_op_reg.oor ? 6'd0 : cur.quality;
            res.distance = b_op_reg.oor ? 14'd0 : cur.distance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[b_addr] <= wdata;
        end
        if (en)
        begin
            rd_reg       <= mem[a_addr];
            b_op_reg     <= op;
            fwd_addr_reg <= b_addr;
            fwd_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg   <= 1'b0;
            valid_reg   <= '0;
            fwd_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b_vld_reg   <= op_vld;
            fwd_vld_reg <= we;
            valid_reg   <= valid_next;
        end
    end

    a_clear_leaves_one: assert property (@(posedge clk) disable iff (!rst_n)
        en && b_vld_reg && b_op_reg.kind == KIND_SAMPLE && b_op_reg.rot_start
        |=> $countones(valid_reg) <= 1)
        else $error("bins not cleared on rotation start");

    a_oor_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld && res.kind == KIND_BIN && res.oor
        |-> res.quality == 6'd0 && res.distance == 14'd0)
        else $error("out-of-range bin read returned data");

    a_no_oor_write: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> !b_op_reg.oor && b_op_reg.kind == KIND_SAMPLE)
        else $error("bin write for an unbinned item");

endmodule

FILE: rtl/lidar_scan_binner_unit.sv
// lidar_scan_binner_unit: top level of the lidar angular binner.
// Depends on lsb_pkg, lsb_parser, lsb_bin_store.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tuser command; tdata link_byte, bin_index
//  m_axis    out  m_axis_tvalid / m_axis_tready   tuser kind; tdata sample or bin fields
//  cfg       in   cfg_valid / cfg_ready           cfg_data min_gap
//
// One item per cycle while the output is not held; a result passes the input register,
// the bin memory read register and the output register in that order.
// Reset clears the parser and all bin valid bits at once, no clearing pass; gap set to max.
// A held output stalls all three stages together; cfg is always ready.
module lidar_scan_binner_unit #(
    parameter int NUM_BINS = lsb_pkg::NUM_BINS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // link_byte[7:0], bin_index[15:8]
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // quality[5:0], angle_deg[14:6], distance[28:15],
                                        // rotation_start[29], scan_ready[30],
                                        // angle_out_of_range[31]
    output logic        m_axis_tuser,   // kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data        // min_gap
);
    import lsb_pkg::*;

    logic        en;
    logic        a_vld_reg;
    cmd_t        a_cmd_reg;
    logic [7:0]  a_byte_reg;
    logic [7:0]  a_bin_reg;
    logic [7:0]  min_gap_reg;
    logic        op_vld;
    op_t         op;
    logic        res_vld;
    op_t         res;
    logic        out_vld_reg;
    op_t         out_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            min_gap_reg <= MIN_GAP_RESET;
        end
        else
        begin
            if (en)
            begin
                a_vld_reg   <= s_axis_tvalid;
                out_vld_reg <= res_vld;
            end
            if (cfg_valid)
            begin
                min_gap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_cmd_reg  <= cmd_t'(s_axis_tuser);
            a_byte_reg <= s_axis_tdata[7:0];
            a_bin_reg  <= s_axis_tdata[15:8];
            out_reg    <= res;
        end
    end

    lsb_parser #(
        .NUM_BINS (NUM_BINS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .a_vld     (a_vld_reg),
        .cmd       (a_cmd_reg),
        .link_byte (a_byte_reg),
        .bin_index (a_bin_reg),
        .min_gap   (min_gap_reg),
        .op_vld    (op_vld),
        .op        (op)
    );

    lsb_bin_store #(
        .NUM_BINS (NUM_BINS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .op_vld  (op_vld),
        .op      (op),
        .res_vld (res_vld),
        .res     (res)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {out_reg.oor, out_reg.scan_ready, out_reg.rot_start,
                            out_reg.distance, out_reg.angle, out_reg.quality};

    a_start_angle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.rot_start |-> out_reg.angle == 9'd0 && out_reg.kind == KIND_SAMPLE)
        else $error("rotation start on a non-zero angle");

    a_ready_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.scan_ready |-> out_reg.rot_start)
        else $error("scan ready without rotation start");

    a_read_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.kind == KIND_BIN |-> !out_reg.rot_start && out_reg.angle == 9'd0)
        else $error("bin read carries sample flags");

endmodule

FILE: tb/tb_lidar_scan_binner_unit.sv
// Self-checking testbench for lidar_scan_binner_unit: a directed table, then random link traffic.
// Frames, noise, bad headers and bin reads are checked against an in-bench predictor.
// Depends on rtl/lsb_pkg.sv and the lidar_scan_binner_unit RTL.
module tb_lidar_scan_binner_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lsb_pkg::*;

    localparam int BINS        = NUM_BINS_DEFAULT;
    localparam int PHASE_ITEMS = 240;
    localparam int DRAIN       = 10;
    localparam int LONG_HOLD   = 400;
    localparam int LIMIT       = 400000;

    // one result, in the m_axis tdata layout with kind on top
    typedef struct packed {
        kind_t       kind;
        logic        oor;
        logic        scan_ready;
        logic        rot_start;
        logic [13:0] distance;
        logic [8:0]  angle;
        logic [5:0]  quality;
    } scan_result_t;

    typedef struct packed {
        cmd_t         cmd;
        logic [7:0]   link_byte;
        logic [7:0]   bin_index;
        logic         typed;
        scan_result_t want;
    } stim_row_t;

    localparam scan_result_t BIN_EMPTY =
        '{KIND_BIN, 1'b0, 1'b0, 1'b0, 14'd0, 9'd0, 6'd0};
    localparam scan_result_t BIN_OOR =
        '{KIND_BIN, 1'b1, 1'b0, 1'b0, 14'd0, 9'd0, 6'd0};
    localparam scan_result_t BIN_FULL =
        '{KIND_BIN, 1'b0, 1'b0, 1'b0, 14'd16383, 9'd0, 6'd63};
    localparam scan_result_t FIRST_ROT =
        '{KIND_SAMPLE, 1'b0, 1'b0, 1'b1, 14'd16383, 9'd0, 6'd63};
    localparam scan_result_t NO_RESULT = '0;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // link_byte[7:0], bin_index[15:8]
    logic        s_axis_tuser  = 1'b0;  // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // quality, angle_deg, distance, rotation_start,
                                        // scan_ready, angle_out_of_range
    logic        m_axis_tuser;          // kind
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data      = '0;

    lidar_scan_binner_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    phase_t      parse_ph    = PH_HEADER;
    logic [2:0]  parse_pos   = '0;
    logic        sync_seen   = 1'b0;
    logic [23:0] remaining   = '0;
    logic [7:0]  body [5]    = '{default: '0};
    logic [7:0]  gap         = GAP_MAX;
    logic        rot_seen    = 1'b0;
    logic [7:0]  min_gap_now = MIN_GAP_RESET;
    logic [5:0]  bin_q [BINS] = '{default: '0};
    logic [13:0] bin_d [BINS] = '{default: '0};

    scan_result_t scan_results_due [$];
    int           failures   = 0;
    int           items_sent = 0;
    int           cycles     = 0;
    bit           calm       = 1'b0;
    bit           hold_start = 1'b0;
    bit           hold_taken = 1'b0;
    int           hold_left  = 0;

    stim_row_t directed_rows [25] = '{
        '{CMD_READ,   8'hFF, 8'd0,   1'b1, BIN_EMPTY},
        '{CMD_READ,   8'hFF, 8'd179, 1'b1, BIN_EMPTY},
        '{CMD_READ,   8'hFF, 8'd180, 1'b1, BIN_OOR},
        '{CMD_READ,   8'hFF, 8'd255, 1'b1, BIN_OOR},
        // angle-zero sample, full quality and distance, starts the first rotation
        '{CMD_STREAM, 8'hA5, 8'hFF,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'h00, 8'hFF,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'h00, 8'hFF,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'h00, 8'hFF,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'h05, 8'hFF,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'hFF, 8'hFF,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'h01, 8'hFF,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'h00, 8'hFF,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'hFF, 8'hFF,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'hFF, 8'hFF,  1'b1, FIRST_ROT},
        '{CMD_READ,   8'h00, 8'd0,   1'b1, BIN_FULL},
        // bad sync with a huge length: no payload taken
        '{CMD_STREAM, 8'h5A, 8'h00,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'hFF, 8'h00,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'hFF, 8'h00,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'hFF, 8'h00,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'hFF, 8'h00,  1'b0, NO_RESULT},
        // zero-length payload
        '{CMD_STREAM, 8'hA5, 8'h00,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'hFF, 8'h00,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'h00, 8'h00,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'h00, 8'h00,  1'b0, NO_RESULT},
        '{CMD_STREAM, 8'h00, 8'h00,  1'b0, NO_RESULT}
    };

    task automatic bump_gap();
        if (gap != GAP_MAX)
            gap++;
    endtask

    task automatic bin_link_item(input cmd_t c, input logic [7:0] b, input logic [7:0] bi,
                                 output bit made, output scan_result_t r);
        logic [5:0] q;
        logic [8:0] ang;
        logic [7:0] slot;
        r    = '0;
        made = 1'b0;
        if (c == CMD_READ)
        begin
            made   = 1'b1;
            r.kind = KIND_BIN;
            if (bi < BINS)
            begin
                r.quality  = bin_q[bi];
                r.distance = bin_d[bi];
            end
            else
                r.oor = 1'b1;
            return;
        end
        if (parse_ph == PH_HEADER)
        begin
            if (parse_pos == 0)
                sync_seen = (b == SYNC_BYTE);
            else if (parse_pos == 2)
                remaining = {16'd0, b};
            else if (parse_pos > 2)
                remaining = {remaining[15:0], b};
            if (parse_pos != HEADER_LAST)
            begin
                parse_pos++;
                return;
            end
            parse_pos = '0;
            if (!sync_seen || remaining == 0)
                bump_gap();
            else
                parse_ph = PH_PAYLOAD;
            return;
        end
        if (parse_pos < SAMPLE_LEN)
        begin
            body[parse_pos] = b;
            parse_pos++;
        end
        remaining--;
        if (remaining != 0)
            return;
        parse_ph = PH_HEADER;
        if (parse_pos < SAMPLE_LEN)
        begin
            parse_pos = '0;
            bump_gap();
            return;
        end
        parse_pos  = '0;
        q          = body[0][7:2];
        ang        = {body[2], body[1][7]};
        slot       = body[2];
        made       = 1'b1;
        r.kind     = KIND_SAMPLE;
        r.quality  = q;
        r.angle    = ang;
        r.distance = {body[4], body[3][7:2]};
        if (ang == 0 && gap > min_gap_now)
        begin
            r.rot_start  = 1'b1;
            r.scan_ready = rot_seen;
            rot_seen     = 1'b1;
            gap          = '0;
            foreach (bin_q[i])
            begin
                bin_q[i] = '0;
                bin_d[i] = '0;
            end
        end
        else
            bump_gap();
        if (slot >= BINS)
            r.oor = 1'b1;
        else if (q > bin_q[slot])
        begin
            bin_q[slot] = q;
            bin_d[slot] = r.distance;
        end
    endtask

    // entered and left at a falling edge
    task automatic send_item(input cmd_t c, input logic [7:0] b, input logic [7:0] bi,
                             input logic typed, input scan_result_t want);
        bit           made;
        scan_result_t r;
        while (!calm && $urandom_range(99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c;
        s_axis_tdata  <= {bi, b};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        bin_link_item(c, b, bi, made, r);
        if (made)
            scan_results_due.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    task automatic send_link_byte(input logic [7:0] b);
        if ($urandom_range(99) < 12)
            send_item(CMD_READ, 8'($urandom),
                      ($urandom_range(9) == 0) ? 8'($urandom_range(255, BINS))
                                               : 8'($urandom_range(BINS - 1)),
                      1'b0, NO_RESULT);
        send_item(CMD_STREAM, b, 8'($urandom), 1'b0, NO_RESULT);
    endtask

    // sends at most cut bytes of the frame
    task automatic send_frame(input logic [23:0] len, input logic [8:0] ang, input int cut);
        logic [7:0] fb [270];
        int         n;
        int         i;
        n = 5 + int'(len);
        fb[0] = SYNC_BYTE;
        fb[1] = 8'($urandom);
        fb[2] = len[23:16];
        fb[3] = len[15:8];
        fb[4] = len[7:0];
        fb[5] = 8'($urandom);
        fb[6] = {ang[0], 7'($urandom)};
        fb[7] = ang[8:1];
        fb[8] = 8'($urandom);
        fb[9] = 8'($urandom);
        for (i = 10; i < n; i++)
            fb[i] = 8'($urandom);
        for (i = 0; i < n && i < cut; i++)
            send_link_byte(fb[i]);
    endtask

    // pad to a header boundary; a sync-valid header is padded with a zero length
    task automatic realign_parser();
        while (parse_ph != PH_HEADER || parse_pos != 0)
            send_link_byte((parse_ph == PH_HEADER && sync_seen && parse_pos >= 2)
                           ? 8'h00 : 8'($urandom));
    endtask

    task automatic write_min_gap(input logic [7:0] v);
        while (scan_results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        min_gap_now = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        int          stop_at;
        int          pick;
        int          n;
        logic [7:0]  b;
        logic [23:0] len;
        logic [8:0]  ang;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            realign_parser();
            pick = $urandom_range(99);
            if (pick < 70 || pick >= 90)
            begin
                n = $urandom_range(99);
                if (n < 60)
                    len = 24'd5;
                else if (n < 80)
                    len = 24'($urandom_range(9, 6));
                else
                    len = 24'($urandom_range(4));
                n = $urandom_range(99);
                if (n < 25)
                    ang = 9'd0;
                else if (n < 35)
                    case ($urandom_range(4))
                        0: ang = 9'd1;
                        1: ang = 9'd358;
                        2: ang = 9'd359;
                        3: ang = 9'd360;
                        default: ang = 9'd511;
                    endcase
                else
                    ang = 9'($urandom_range(511));
                // the last tenth of the draws are frames cut short
                send_frame(len, ang, (pick >= 90) ? $urandom_range(9, 1) : 270);
            end
            else if (pick < 80)
            begin
                b = 8'($urandom);
                send_link_byte((b == SYNC_BYTE) ? ~b : b);
                repeat (4) send_link_byte(8'($urandom));
            end
            else
            begin
                n = $urandom_range(4, 1);
                repeat (n)
                begin
                    b = 8'($urandom);
                    if (parse_ph == PH_HEADER && parse_pos == 0 && b == SYNC_BYTE)
                        b = ~b;
                    send_link_byte(b);
                end
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        scan_result_t got;
        scan_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata};
            if (scan_results_due.size() == 0)
            begin
                $error("result with none outstanding: kind %0d tdata %h", got.kind,
                       m_axis_tdata);
                failures++;
            end
            else
            begin
                want = scan_results_due.pop_front();
                check_field("kind", 16'(want.kind), 16'(got.kind));
                check_field("quality", 16'(want.quality), 16'(got.quality));
                check_field("angle_deg", 16'(want.angle), 16'(got.angle));
                check_field("distance", 16'(want.distance), 16'(got.distance));
                check_field("rotation_start", 16'(want.rot_start), 16'(got.rot_start));
                check_field("scan_ready", 16'(want.scan_ready), 16'(got.scan_ready));
                check_field("angle_out_of_range", 16'(want.oor), 16'(got.oor));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_start && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (calm)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 30);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] gap_settings [5];
        int         k;
        gap_settings = '{MIN_GAP_RESET, 8'd0, 8'd255, 8'($urandom_range(30, 1)), 8'd3};
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].link_byte,
                      directed_rows[i].bin_index, directed_rows[i].typed,
                      directed_rows[i].want);

        for (k = 0; k < 5; k++)
        begin
            if (k > 0)
            begin
                s_axis_tvalid <= 1'b0;
                write_min_gap(gap_settings[k]);
            end
            calm       = (k == 1);
            hold_start = (k == 3);
            if (k == 2)
                send_frame(24'd259, 9'd0, 270);
            random_traffic(PHASE_ITEMS);
        end
        s_axis_tvalid <= 1'b0;

        while (scan_results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0 && scan_results_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
